FILE: design/fixed_partition_fit_allocator_macros.svh
// ----------------------------------------------------------------------------
// Fixed partition fit allocator assertion macros
// Clocked assertion shorthands with reset disable, used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH

// Check a property in the same cycle.
`define FPFA_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define FPFA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed partition fit allocator package
// Sizes, operation codes, controller states and the structs between modules.
// ----------------------------------------------------------------------------
package fpfa_pkg;

	localparam int NUM_PARTS = 32;
	localparam int SIZE_BITS = 16;
	localparam int IDX_BITS  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
	localparam int CNT_BITS  = $clog2(NUM_PARTS + 1);

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Search token that walks down the cell row.
	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [IDX_BITS-1:0]  idx;
		logic [SIZE_BITS-1:0] psize;
		logic [SIZE_BITS-1:0] rem;
	} tok_t;

	// Table update broadcast to every cell.
	typedef struct packed {
		logic                 load;
		logic                 clear;
		logic                 mark;
		logic [IDX_BITS-1:0]  idx;
		logic [SIZE_BITS-1:0] psize;
	} cmd_t;

endpackage

FILE: design/fpfa_cell.sv
// ----------------------------------------------------------------------------
// Fixed partition fit allocator cell
// Holds one partition's size and used mark; updates the passing search token.
// ----------------------------------------------------------------------------
module fpfa_cell
	import fpfa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IDX_BITS-1:0]  cell_idx,
	input  logic [CNT_BITS-1:0]  count,
	input  logic [SIZE_BITS-1:0] req,
	input  logic                 mode,
	input  cmd_t                 cmd,
	input  tok_t                 tok_in,
	output tok_t                 tok_out
);

	logic [SIZE_BITS-1:0] size_q;
	logic                 used_q;
	logic                 hit;
	logic                 active;
	logic                 eligible;
	logic                 take;
	logic [SIZE_BITS-1:0] rem;
	tok_t                 tok_q;
	tok_t                 tok_d;

	assign hit      = (cmd.idx == cell_idx);
	assign active   = (CNT_BITS'(cell_idx) < count);
	assign eligible = active && !used_q && (size_q >= req);
	assign rem      = size_q - req;
	// first fit keeps the earliest hit; worst fit replaces on a strictly larger remainder
	assign take     = eligible && (!tok_in.found || (mode && (rem > tok_in.rem)));

	always_comb begin
		tok_d = tok_in;
		if (take) begin
			tok_d.found = 1'b1;
			tok_d.idx   = cell_idx;
			tok_d.psize = size_q;
			tok_d.rem   = rem;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && hit) begin
			size_q <= cmd.psize;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (cmd.clear || (cmd.load && hit)) begin
			used_q <= 1'b0;
		end else if (cmd.mark && hit) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: design/fixed_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// Fixed partition fit allocator
// Partition table with first fit and worst fit allocation over a cell row.
// ----------------------------------------------------------------------------
//
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------
// input    | in_valid / in_stall        | op, size_value
// result   | out_valid / out_stall      | ok, part_index, part_size, leftover
// config   | cfg_valid / cfg_ready      | cfg_data (fit_mode)
//
// An allocate goes through accept, token launch, the search token walking
// the row through each cell's register, and one write-back.
// Load, clear and unknown codes go through accept and write-back.
// Reset clears the used marks, the partition count and fit_mode; sizes are
// held only in flops without reset and are read only after a load.
// A stalled result holds the write-back; the next transfer is taken as soon
// as the write-back has landed in the output register.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator
	import fpfa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic [SIZE_BITS-1:0] size_value,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 ok,
	output logic [IDX_BITS-1:0]  part_index,
	output logic [SIZE_BITS-1:0] part_size,
	output logic [SIZE_BITS-1:0] leftover,
	// configuration channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data
);

	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(NUM_PARTS);

	state_t               state_q;
	state_t               state_d;
	logic [1:0]           op_q;
	logic [SIZE_BITS-1:0] req_q;
	logic                 mode_q;
	logic [CNT_BITS-1:0]  count_q;
	logic                 start_q;
	tok_t                 best_q;

	logic                 out_valid_q;
	logic                 ok_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [SIZE_BITS-1:0] left_q;

	logic                 in_fire;
	logic                 out_free;
	logic                 res_load;
	cmd_t                 cmd;
	logic                 res_ok;
	logic [IDX_BITS-1:0]  res_idx;
	logic [SIZE_BITS-1:0] res_size;
	logic [SIZE_BITS-1:0] res_left;
	logic [CNT_BITS-1:0]  count_d;

	tok_t                 chain [0:NUM_PARTS];

	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// ---- cell row --------------------------------------------------------
	// launch an empty token into the first cell in the cycle after an allocate is taken
	always_comb begin
		chain[0]       = '0;
		chain[0].valid = start_q;
	end

	for (genvar i = 0; i < NUM_PARTS; i++) begin : g_cell
		fpfa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_BITS'(i)),
			.count    (count_q),
			.req      (req_q),
			.mode     (mode_q),
			.cmd      (cmd),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1])
		);
	end

	// ---- controller ------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (op == OP_ALLOC) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (chain[NUM_PARTS].valid) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Build the result and the table update for the item being retired.
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		res_load = (state_q == ST_DONE) && out_free;
		cmd      = '0;
		cmd.idx  = count_q[IDX_BITS-1:0];
		cmd.psize = req_q;
		res_ok   = 1'b0;
		res_idx  = '0;
		res_size = '0;
		res_left = '0;
		count_d  = count_q;
		unique case (op_q)
			OP_LOAD: begin
				if (count_q < CNT_FULL) begin
					cmd.load = res_load;
					res_ok   = 1'b1;
					res_idx  = count_q[IDX_BITS-1:0];
					res_size = req_q;
					count_d  = count_q + CNT_BITS'(1);
				end
			end
			OP_ALLOC: begin
				if (best_q.found) begin
					cmd.mark = res_load;
					cmd.idx  = best_q.idx;
					res_ok   = 1'b1;
					res_idx  = best_q.idx;
					res_size = best_q.psize;
					res_left = best_q.rem;
				end
			end
			OP_CLEAR: begin
				cmd.clear = res_load;
				count_d   = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			count_q     <= '0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= in_fire && (op == OP_ALLOC);
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (res_load) begin
				count_q <= count_d;
			end
			// hold the result until the consumer takes the transfer
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= op;
			req_q <= size_value;
		end
		// capture the winner as the token leaves the last cell
		if ((state_q == ST_SCAN) && chain[NUM_PARTS].valid) begin
			best_q <= chain[NUM_PARTS];
		end
		if (res_load) begin
			ok_q   <= res_ok;
			idx_q  <= res_idx;
			size_q <= res_size;
			left_q <= res_left;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign part_index = idx_q;
	assign part_size  = size_q;
	assign leftover   = left_q;

endmodule

FILE: design/fpfa_checker.sv
// ----------------------------------------------------------------------------
// Fixed partition fit allocator port checker
// Watches the top level ports for result hold and result consistency.
// ----------------------------------------------------------------------------
`include "fixed_partition_fit_allocator_macros.svh"

module fpfa_port_checker
	import fpfa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           op,
	input  logic [SIZE_BITS-1:0] size_value,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 ok,
	input  logic [IDX_BITS-1:0]  part_index,
	input  logic [SIZE_BITS-1:0] part_size,
	input  logic [SIZE_BITS-1:0] leftover,
	input  logic                 cfg_valid,
	input  logic                 cfg_data
);

	logic pending;
	logic in_seen;

	assign pending = out_valid && out_stall;
	assign in_seen = in_valid || cfg_valid || (|op) || (|size_value) || cfg_data;

	// a stalled result stays up
	`FPFA_ASSERT_NEXT(a_out_hold, clk, arst_n, pending, out_valid, "result dropped while stalled")

	// a stalled result keeps its index and size
	`FPFA_ASSERT_NEXT(a_out_stable, clk, arst_n, pending,
		$stable(part_index) && $stable(part_size), "result changed while stalled")

	// a failed or empty result carries only zeros
	`FPFA_ASSERT(a_fail_zero, clk, arst_n,
		!(out_valid && !ok) || ((part_index == '0) && (part_size == '0) && (leftover == '0)),
		"failed result with nonzero fields")

	// the fragment never exceeds the partition it came from
	`FPFA_ASSERT(a_left_fits, clk, arst_n, !(out_valid && ok) || (leftover <= part_size),
		"leftover larger than partition")

	// the controller never takes an item in the cycle after taking one
	`FPFA_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && !in_stall && in_seen, in_stall,
		"input taken on consecutive cycles")

endmodule

bind fixed_partition_fit_allocator fpfa_port_checker u_fpfa_port_checker (.*);
